>>> rtl/core/tser_pkg.sv
`timescale 1ns / 1ps

package tser_pkg;

    // Delay line lengths in samples.
    localparam int LONG_DELAY  = 2048;
    localparam int SHORT_DELAY = 256;

    // Address widths that follow from the line lengths.
    localparam int LONG_AW  = $clog2(LONG_DELAY);
    localparam int SHORT_AW = $clog2(SHORT_DELAY);

    // Width of one audio sample.
    localparam int SAMPLE_W = 16;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Half of a sample, truncated toward zero, one bit wider than the sample.
    function automatic logic signed [SAMPLE_W:0] half_trunc(input t_sample x);
        logic signed [SAMPLE_W:0] ext;
        logic signed [SAMPLE_W:0] adj;
        ext = $signed({x[SAMPLE_W-1], x});
        adj = $signed({{SAMPLE_W{1'b0}}, x[SAMPLE_W-1]});
        return (ext + adj) >>> 1;
    endfunction

    // One comb stage: a nonzero echo gives x/2 + echo/2, otherwise x passes.
    // The sum of two halves always fits the sample width.
    function automatic t_sample comb_mix(input t_sample x, input t_sample echo);
        logic signed [SAMPLE_W:0] sum;
        sum = half_trunc(x) + half_trunc(echo);
        if (echo != '0) begin
            return sum[SAMPLE_W-1:0];
        end
        return x;
    endfunction

endpackage

>>> rtl/core/tser_ram.sv
`timescale 1ns / 1ps

// Simple dual-port memory: one write port, one registered read port.
module tser_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/two_stage_echo_reverb_top.sv
`timescale 1ns / 1ps
// Path: an accepted request passes stage one, stage two and the output register.
// Throughput: one sample per cycle while the output is not held back by i_out_ready;
// both delay-line reads use the slot pointers only, so each memory sees one read and one write per cycle.
// Reset: synchronous, active low; the pointers, valid bits and block flag clear at once.
// The lines read as zero until their pointer wraps the first time, so no clearing pass.
module two_stage_echo_reverb_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_sample_in,
    input  logic        i_block_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_sample_out,
    output logic        o_echo_mixed,
    output logic        o_block_done,
    output logic        o_block_dirty
);

    // Handshake between the stages.
    logic out_free;
    logic s2_fire;
    logic s2_free;
    logic s1_fire;
    logic s1_free;
    logic accept;

    // Slot pointers and first-wrap flags.
    logic [tser_pkg::LONG_AW-1:0]  r_long_ptr;
    logic [tser_pkg::SHORT_AW-1:0] r_short_ptr;
    logic                          r_long_wrapped;
    logic                          r_short_wrapped;

    // Stage one: memory reads in flight.
    logic                          r_s1_valid;
    tser_pkg::t_sample             r_s1_sample;
    logic                          r_s1_end;
    logic                          r_s1_long_ok;
    logic                          r_s1_short_ok;
    logic [tser_pkg::LONG_AW-1:0]  r_s1_long_addr;
    logic [tser_pkg::SHORT_AW-1:0] r_s1_short_addr;

    // Stage two: long line mixed, short echo held.
    logic                          r_s2_valid;
    tser_pkg::t_sample             r_s2_sample;
    logic                          r_s2_mixed;
    logic                          r_s2_end;
    tser_pkg::t_sample             r_s2_short_echo;
    logic [tser_pkg::SHORT_AW-1:0] r_s2_short_addr;

    // Output register and block flag.
    logic                          r_out_valid;
    tser_pkg::t_sample             r_out_sample;
    logic                          r_out_mixed;
    logic                          r_out_done;
    logic                          r_out_dirty;
    logic                          r_dirty_seen;

    // Memory data and computed next values.
    logic [tser_pkg::SAMPLE_W-1:0] long_rdata;
    logic [tser_pkg::SAMPLE_W-1:0] short_rdata;
    tser_pkg::t_sample             long_echo;
    tser_pkg::t_sample             short_echo;
    tser_pkg::t_sample             n_s2_sample;
    logic                          n_s2_mixed;
    tser_pkg::t_sample             n_out_sample;
    logic                          n_out_mixed;
    logic                          n_dirty;

    // Each stage moves on when the one after it is empty or moving.
    assign out_free   = !r_out_valid || i_out_ready;
    assign s2_fire    = r_s2_valid && out_free;
    assign s2_free    = !r_s2_valid || out_free;
    assign s1_fire    = r_s1_valid && s2_free;
    assign s1_free    = !r_s1_valid || s2_free;
    assign accept     = i_in_valid && s1_free;
    assign o_in_ready = s1_free;

    // Long delay line.
    tser_ram #(
        .DEPTH (tser_pkg::LONG_DELAY),
        .WIDTH (tser_pkg::SAMPLE_W)
    ) u_long_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_long_addr),
        .i_wdata (n_s2_sample),
        .i_re    (accept),
        .i_raddr (r_long_ptr),
        .o_rdata (long_rdata)
    );

    // Short delay line.
    tser_ram #(
        .DEPTH (tser_pkg::SHORT_DELAY),
        .WIDTH (tser_pkg::SAMPLE_W)
    ) u_short_ram (
        .i_clk   (i_clk),
        .i_we    (s2_fire),
        .i_waddr (r_s2_short_addr),
        .i_wdata (n_out_sample),
        .i_re    (accept),
        .i_raddr (r_short_ptr),
        .o_rdata (short_rdata)
    );

    // Pointers advance once per accepted request and remember the first wrap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ptr      <= '0;
            r_short_ptr     <= '0;
            r_long_wrapped  <= 1'b0;
            r_short_wrapped <= 1'b0;
        end else if (accept) begin
            if (r_long_ptr == tser_pkg::LONG_AW'(tser_pkg::LONG_DELAY - 1)) begin
                r_long_ptr     <= '0;
                r_long_wrapped <= 1'b1;
            end else begin
                r_long_ptr <= r_long_ptr + 1'b1;
            end
            if (r_short_ptr == tser_pkg::SHORT_AW'(tser_pkg::SHORT_DELAY - 1)) begin
                r_short_ptr     <= '0;
                r_short_wrapped <= 1'b1;
            end else begin
                r_short_ptr <= r_short_ptr + 1'b1;
            end
        end
    end

    // Stage one valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_in_valid;
        end
    end

    // Stage one payload; a slot never written before the first wrap reads as zero.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sample     <= i_sample_in;
            r_s1_end        <= i_block_end;
            r_s1_long_ok    <= r_long_wrapped;
            r_s1_short_ok   <= r_short_wrapped;
            r_s1_long_addr  <= r_long_ptr;
            r_s1_short_addr <= r_short_ptr;
        end
    end

    // Long stage mix.
    always_comb begin
        long_echo   = r_s1_long_ok ? tser_pkg::t_sample'(long_rdata) : '0;
        n_s2_sample = tser_pkg::comb_mix(r_s1_sample, long_echo);
        n_s2_mixed  = (long_echo != '0);
    end

    // Stage two valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    // Stage two payload; the short echo is captured before the next read replaces it.
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_s2_sample     <= n_s2_sample;
            r_s2_mixed      <= n_s2_mixed;
            r_s2_end        <= r_s1_end;
            r_s2_short_echo <= r_s1_short_ok ? tser_pkg::t_sample'(short_rdata) : '0;
            r_s2_short_addr <= r_s1_short_addr;
        end
    end

    // Short stage mix and the block flag.
    always_comb begin
        short_echo   = r_s2_short_echo;
        n_out_sample = tser_pkg::comb_mix(r_s2_sample, short_echo);
        n_out_mixed  = r_s2_mixed || (short_echo != '0);
        n_dirty      = r_dirty_seen || n_out_mixed;
    end

    // Output valid bit and the flag that spans a block.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_dirty_seen <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_s2_valid;
            end
            if (s2_fire) begin
                r_dirty_seen <= r_s2_end ? 1'b0 : n_dirty;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_out_sample <= n_out_sample;
            r_out_mixed  <= n_out_mixed;
            r_out_done   <= r_s2_end;
            r_out_dirty  <= r_s2_end && n_dirty;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_sample_out  = r_out_sample;
    assign o_echo_mixed  = r_out_mixed;
    assign o_block_done  = r_out_done;
    assign o_block_dirty = r_out_dirty;

endmodule
